// File: hw/rtl/ecsp_pkg.sv
// Shared types and constants of the stripe segment planner.
package ecsp_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_CHUNK_BYTES = 2'd0;
  localparam logic [1:0] REG_DATA_SHARDS = 2'd1;
  localparam logic [1:0] REG_SHARD_INDEX = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] CHUNK_BYTES_RST = 32'd4096;
  localparam logic [7:0]  DATA_SHARDS_RST = 8'd1;
  localparam logic [7:0]  SHARD_INDEX_RST = 8'd0;

  // One classified request, handed from the front part to the back part.
  typedef struct packed {
    logic        is_empty;
    logic [63:0] dest_base;
    logic [63:0] read_offset;
    logic [63:0] read_end;
    logic [63:0] data_length;
    logic [63:0] first_chunk;
    logic [63:0] last_chunk;
    logic [63:0] chunk_start;
    logic [63:0] chunk_end;
    logic [39:0] stride_bytes;
    logic [7:0]  data_shards;
  } desc_t;

  // One placement segment as it leaves the block.
  typedef struct packed {
    logic [63:0] reply_offset;
    logic [63:0] dest_offset;
    logic [63:0] segment_length;
    logic        last;
    logic        truncated;
  } seg_t;

endpackage

// File: hw/rtl/ecsp_front.sv
// Front part: accepts a request, divides by the chunk size and finds the first owned chunk.
module ecsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [63:0]         in_dest_base,
  input  logic [63:0]         in_read_offset,
  input  logic [63:0]         in_read_length,
  input  logic [63:0]         in_data_length,
  input  logic [31:0]         chunk_bytes,
  input  logic [7:0]          data_shards,
  input  logic [7:0]          shard_index,
  output logic                desc_push,
  output ecsp_pkg::desc_t     desc_data,
  input  logic                desc_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_MODT = 5'b00100,
    F_MUL  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [5:0]  cnt_r;
  logic        empty_r;
  logic [63:0] base_r, roff_r, roend_r, dlen_r;
  logic [63:0] q0_r, q1_r;
  logic [31:0] rem0_r, rem1_r;
  logic [7:0]  mr_r;
  logic [8:0]  tsh_r;
  logic [7:0]  tr_r;
  logic [63:0] c_r, prod_r;

  logic        accept;
  logic [32:0] x0, x1, cs_ext;
  logic        ge0, ge1;
  logic [8:0]  y, z, k_ext;
  logic [7:0]  mr_n, tr_n;
  logic [63:0] addend;

  assign accept  = in_push && (state_r == F_IDLE);
  assign in_full = (state_r != F_IDLE);

  // One restoring step of both quotients; the low quotient feeds the modulo by k.
  always_comb begin
    cs_ext = {1'b0, chunk_bytes};
    k_ext  = {1'b0, data_shards};
    x0  = {rem0_r, q0_r[63]};
    x1  = {rem1_r, q1_r[63]};
    ge0 = (x0 >= cs_ext);
    ge1 = (x1 >= cs_ext);
    if (ge0) x0 = x0 - cs_ext;
    if (ge1) x1 = x1 - cs_ext;
    y = {mr_r, ge0};
    if (y >= k_ext) y = y - k_ext;
    mr_n = y[7:0];
    z = {tr_r, tsh_r[8]};
    if (z >= k_ext) z = z - k_ext;
    tr_n = z[7:0];
    addend = chunk_bytes[~cnt_r[4:0]] ? c_r : 64'd0;
  end

  // Sequencing of the request.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          if (in_read_length == 64'd0 || chunk_bytes == 32'd0 ||
              data_shards == 8'd0 || in_data_length == 64'd0) begin
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV:  if (cnt_r == 6'd63) state_nxt = F_MODT;
      F_MODT: if (cnt_r == 6'd8) state_nxt = F_MUL;
      F_MUL:  if (cnt_r == 6'd31) state_nxt = F_PUSH;
      F_PUSH: if (!desc_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          base_r  <= in_dest_base;
          roff_r  <= in_read_offset;
          roend_r <= in_read_offset + in_read_length;
          dlen_r  <= in_data_length;
          q0_r    <= in_read_offset;
          q1_r    <= in_read_offset + in_read_length - 64'd1;
          rem0_r  <= 32'd0;
          rem1_r  <= 32'd0;
          mr_r    <= 8'd0;
          empty_r <= (in_read_length == 64'd0 || chunk_bytes == 32'd0 ||
                      data_shards == 8'd0 || in_data_length == 64'd0);
        end
      end
      F_DIV: begin
        q0_r   <= {q0_r[62:0], ge0};
        q1_r   <= {q1_r[62:0], ge1};
        rem0_r <= x0[31:0];
        rem1_r <= x1[31:0];
        mr_r   <= mr_n;
        if (cnt_r == 6'd63) begin
          tsh_r <= {1'b0, shard_index} + {1'b0, data_shards} - {1'b0, mr_n};
          tr_r  <= 8'd0;
        end
      end
      F_MODT: begin
        tsh_r <= {tsh_r[7:0], 1'b0};
        tr_r  <= tr_n;
        if (cnt_r == 6'd8) begin
          c_r    <= q0_r + {56'd0, tr_n};
          prod_r <= 64'd0;
        end
      end
      F_MUL: begin
        prod_r <= {prod_r[62:0], 1'b0} + addend;
      end
      default: ;
    endcase
  end

  // Descriptor toward the back part.
  always_comb begin
    desc_push              = (state_r == F_PUSH) && !desc_full;
    desc_data.is_empty     = empty_r;
    desc_data.dest_base    = base_r;
    desc_data.read_offset  = roff_r;
    desc_data.read_end     = roend_r;
    desc_data.data_length  = dlen_r;
    desc_data.first_chunk  = c_r;
    desc_data.last_chunk   = q1_r;
    desc_data.chunk_start  = prod_r;
    desc_data.chunk_end    = prod_r + {32'd0, chunk_bytes};
    desc_data.stride_bytes = {32'd0, data_shards} * {8'd0, chunk_bytes};
    desc_data.data_shards  = data_shards;
  end

endmodule

// File: hw/rtl/ecsp_desc_fifo.sv
// Two-entry queue of request descriptors between the front and back parts.
module ecsp_desc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ecsp_pkg::desc_t din,
  output logic            full,
  input  logic            pop,
  output ecsp_pkg::desc_t dout,
  output logic            empty
);

  ecsp_pkg::desc_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

endmodule

// File: hw/rtl/ecsp_back.sv
// Back part: walks the owned chunks of one request and emits placement segments.
module ecsp_back #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                desc_empty,
  input  ecsp_pkg::desc_t     desc_data,
  output logic                desc_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output ecsp_pkg::seg_t      out_seg
);

  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_SEGMENTS);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_CHECK = 5'b00010,
    B_CALC  = 5'b00100,
    B_EMIT  = 5'b01000,
    B_UPD   = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [63:0] c_r, cn_r, sch_r, sche_r, roff_r, roend_r, base_r, stride_r;
  logic [63:0] reply_r, rem_r, s_r, e_r;
  logic [7:0]  k_r;
  logic [NW-1:0] n_r;
  logic        pend_v_r;
  ecsp_pkg::seg_t pend_r;
  logic        out_v_r;
  ecsp_pkg::seg_t out_r;

  logic        ofree, cond, out_wr;
  ecsp_pkg::seg_t out_w;
  logic [63:0] raw_len, seg_len;

  assign ofree     = !out_v_r || out_pop;
  assign cond      = (c_r <= cn_r) && (rem_r != 64'd0);
  assign out_empty = !out_v_r;
  assign out_seg   = out_r;
  assign raw_len   = e_r - s_r;
  assign seg_len   = (raw_len > rem_r) ? rem_r : raw_len;

  // Loop control and result selection.
  always_comb begin
    state_nxt = state_r;
    desc_pop  = 1'b0;
    out_wr    = 1'b0;
    out_w     = '0;
    out_w.last = 1'b1;
    case (state_r)
      B_IDLE: begin
        if (!desc_empty) begin
          if (desc_data.is_empty) begin
            if (ofree) begin
              desc_pop = 1'b1;
              out_wr   = 1'b1;
            end
          end else begin
            desc_pop  = 1'b1;
            state_nxt = B_CHECK;
          end
        end
      end
      B_CHECK: begin
        if (ofree) begin
          if (!cond) begin
            out_wr = 1'b1;
            if (pend_v_r) out_w = pend_r;
            out_w.last = 1'b1;
            state_nxt  = B_IDLE;
          end else if (n_r >= MAX_N) begin
            out_wr          = 1'b1;
            out_w           = pend_r;
            out_w.last      = 1'b1;
            out_w.truncated = 1'b1;
            state_nxt       = B_IDLE;
          end else begin
            out_wr     = pend_v_r;
            out_w      = pend_r;
            out_w.last = 1'b0;
            state_nxt  = B_CALC;
          end
        end
      end
      B_CALC: state_nxt = B_EMIT;
      B_EMIT: state_nxt = B_UPD;
      B_UPD:  state_nxt = B_CHECK;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_wr) out_v_r <= 1'b1;
      else if (out_pop) out_v_r <= 1'b0;
      if (desc_pop) begin
        pend_v_r <= 1'b0;
        n_r      <= '0;
      end else if (state_r == B_EMIT) begin
        pend_v_r <= 1'b1;
        n_r      <= n_r + NW'(1);
      end
    end
  end

  // Chunk walk datapath.
  always_ff @(posedge clk) begin
    if (out_wr) out_r <= out_w;
    case (state_r)
      B_IDLE: begin
        if (desc_pop) begin
          c_r      <= desc_data.first_chunk;
          cn_r     <= desc_data.last_chunk;
          sch_r    <= desc_data.chunk_start;
          sche_r   <= desc_data.chunk_end;
          roff_r   <= desc_data.read_offset;
          roend_r  <= desc_data.read_end;
          base_r   <= desc_data.dest_base;
          stride_r <= {24'd0, desc_data.stride_bytes};
          k_r      <= desc_data.data_shards;
          reply_r  <= 64'd0;
          rem_r    <= desc_data.data_length;
        end
      end
      B_CALC: begin
        s_r <= (sch_r < roff_r) ? roff_r : sch_r;
        e_r <= (sche_r > roend_r) ? roend_r : sche_r;
      end
      B_EMIT: begin
        pend_r.reply_offset   <= reply_r;
        pend_r.dest_offset    <= base_r + s_r - roff_r;
        pend_r.segment_length <= seg_len;
        pend_r.last           <= 1'b0;
        pend_r.truncated      <= 1'b0;
      end
      B_UPD: begin
        reply_r <= reply_r + pend_r.segment_length;
        rem_r   <= rem_r - pend_r.segment_length;
        c_r     <= c_r + {56'd0, k_r};
        sch_r   <= sch_r + stride_r;
        sche_r  <= sche_r + stride_r;
      end
      default: ;
    endcase
  end

  // The segment count never passes the limit.
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n) n_r <= MAX_N)
    else $error("segment count above limit");

  // A truncated result always closes its request.
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.truncated |-> out_r.last)
    else $error("truncated result without last");

  // A pending segment never asks for more data than is left.
  a_len_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_UPD |-> pend_r.segment_length <= rem_r)
    else $error("segment longer than remaining data");

  // A new result is only written into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |-> (!out_v_r || out_pop))
    else $error("result overwritten");

endmodule

// File: hw/rtl/ec_stripe_segment_planner_core.sv
// Top level of the erasure-code stripe segment planner.
// A request with nothing to place goes straight to the front part's hand-over; otherwise it
// passes the one-bit-per-cycle chunk divider with its modulo by k, the shard offset modulo,
// the shift-add chunk start multiply and the hand-over. The back part picks up the request,
// takes each segment through check, calc, emit and update, and closes the request in check;
// an empty plan leaves in the pick-up cycle. A two-entry descriptor queue lets the front
// part work on the next request while segments are emitted. Results queue behind a one-entry
// output register and stall the back part while it is full; at most MAX_SEGMENTS per request.
module ec_stripe_segment_planner_core #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_dest_base,
  input  logic [63:0] in_read_offset,
  input  logic [63:0] in_read_length,
  input  logic [63:0] in_data_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_reply_offset,
  output logic [63:0] out_dest_offset,
  output logic [63:0] out_segment_length,
  output logic        out_last,
  output logic        out_truncated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] chunk_bytes_r;
  logic [7:0]  data_shards_r, shard_index_r;

  logic            desc_push, desc_full, desc_pop, desc_empty;
  ecsp_pkg::desc_t desc_in, desc_out;
  ecsp_pkg::seg_t  seg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_bytes_r <= ecsp_pkg::CHUNK_BYTES_RST;
      data_shards_r <= ecsp_pkg::DATA_SHARDS_RST;
      shard_index_r <= ecsp_pkg::SHARD_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ecsp_pkg::REG_CHUNK_BYTES: chunk_bytes_r <= cfg_data;
        ecsp_pkg::REG_DATA_SHARDS: data_shards_r <= cfg_data[7:0];
        ecsp_pkg::REG_SHARD_INDEX: shard_index_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ecsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_dest_base   (in_dest_base),
    .in_read_offset (in_read_offset),
    .in_read_length (in_read_length),
    .in_data_length (in_data_length),
    .chunk_bytes    (chunk_bytes_r),
    .data_shards    (data_shards_r),
    .shard_index    (shard_index_r),
    .desc_push      (desc_push),
    .desc_data      (desc_in),
    .desc_full      (desc_full)
  );

  ecsp_desc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .din   (desc_in),
    .full  (desc_full),
    .pop   (desc_pop),
    .dout  (desc_out),
    .empty (desc_empty)
  );

  ecsp_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_empty (desc_empty),
    .desc_data  (desc_out),
    .desc_pop   (desc_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_seg    (seg)
  );

  assign out_reply_offset   = seg.reply_offset;
  assign out_dest_offset    = seg.dest_offset;
  assign out_segment_length = seg.segment_length;
  assign out_last           = seg.last;
  assign out_truncated      = seg.truncated;

endmodule

// File: test/tb_ec_stripe_segment_planner_core.sv
// Self-checking testbench of the stripe segment planner: directed table, then random phases.
`timescale 1ns / 100ps

module tb_ec_stripe_segment_planner_core;

  localparam int SEG_LIMIT = 64;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [63:0] in_dest_base;
  logic [63:0] in_read_offset;
  logic [63:0] in_read_length;
  logic [63:0] in_data_length;
  logic        out_empty;
  logic        out_pop;
  logic [63:0] out_reply_offset;
  logic [63:0] out_dest_offset;
  logic [63:0] out_segment_length;
  logic        out_last;
  logic        out_truncated;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // One request row of the directed table; a typed row also gives its first planned segment.
  typedef struct {
    logic [63:0]    dest_base;
    logic [63:0]    read_offset;
    logic [63:0]    read_length;
    logic [63:0]    data_length;
    bit             typed;
    ecsp_pkg::seg_t seg;
  } request_t;

  // Shadow copy of the configuration registers.
  logic [31:0] cur_chunk_bytes;
  logic [7:0]  shard_count;
  logic [7:0]  shard_sel;

  ecsp_pkg::seg_t planned_segs[$];
  request_t       sent_reqs[$];
  int             fail_count;
  int             send_idle_pct;
  int             pop_stall_pct;

  ec_stripe_segment_planner_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Work out the placement segments of one request under the shadow configuration.
  function automatic void plan_segments(request_t r);
    logic [63:0]    cs, k, ro_end, c0, cn, c, reply, s, e, len;
    int             n;
    bit             cut;
    ecsp_pkg::seg_t sg;
    cs = {32'd0, cur_chunk_bytes};
    k = {56'd0, shard_count};
    n = 0;
    cut = 1'b0;
    reply = '0;
    if (r.read_length == 0 || cs == 0 || k == 0 || r.data_length == 0) begin
      planned_segs.insert(planned_segs.size(), '{64'd0, 64'd0, 64'd0, 1'b1, 1'b0});
      return;
    end
    ro_end = r.read_offset + r.read_length;
    c0 = r.read_offset / cs;
    cn = (ro_end - 64'd1) / cs;
    c = c0 + (({56'd0, shard_sel} + k - (c0 % k)) % k);
    while (c <= cn && reply < r.data_length) begin
      if (n >= SEG_LIMIT) begin
        cut = 1'b1;
        break;
      end
      s = c * cs;
      if (s < r.read_offset) s = r.read_offset;
      e = (c + 64'd1) * cs;
      if (e > ro_end) e = ro_end;
      len = e - s;
      if (len > r.data_length - reply) len = r.data_length - reply;
      sg = '{reply, r.dest_base + (s - r.read_offset), len, 1'b0, 1'b0};
      planned_segs.insert(planned_segs.size(), sg);
      n++;
      reply += len;
      c += k;
    end
    if (n == 0) begin
      planned_segs.insert(planned_segs.size(), '{64'd0, 64'd0, 64'd0, 1'b1, 1'b0});
      return;
    end
    planned_segs[$].last = 1'b1;
    planned_segs[$].truncated = cut;
  endfunction

  // Predict at each accepted item; a typed row must agree with the predictor too.
  always @(posedge clk) begin
    request_t r;
    int       first;
    if (rst_n && in_push && !in_full) begin
      r = sent_reqs.pop_front();
      first = planned_segs.size();
      plan_segments(r);
      if (r.typed && planned_segs[first] != r.seg) begin
        $error("typed row: expected %p actual %p", r.seg, planned_segs[first]);
        fail_count++;
      end
    end
  end

  // Compare each accepted result with the oldest planned segment.
  always @(posedge clk) begin
    ecsp_pkg::seg_t exp_seg;
    if (rst_n && out_pop && !out_empty) begin
      if (planned_segs.size() == 0) begin
        $error("result with no segment planned");
        fail_count++;
      end else begin
        exp_seg = planned_segs.pop_front();
        if (out_reply_offset !== exp_seg.reply_offset) begin
          $error("reply_offset: expected %h actual %h", exp_seg.reply_offset, out_reply_offset);
          fail_count++;
        end
        if (out_dest_offset !== exp_seg.dest_offset) begin
          $error("dest_offset: expected %h actual %h", exp_seg.dest_offset, out_dest_offset);
          fail_count++;
        end
        if (out_segment_length !== exp_seg.segment_length) begin
          $error("segment_length: expected %h actual %h", exp_seg.segment_length,
                 out_segment_length);
          fail_count++;
        end
        if (out_last !== exp_seg.last) begin
          $error("last: expected %b actual %b", exp_seg.last, out_last);
          fail_count++;
        end
        if (out_truncated !== exp_seg.truncated) begin
          $error("truncated: expected %b actual %b", exp_seg.truncated, out_truncated);
          fail_count++;
        end
      end
    end
  end

  // Receiver side: stall at random per the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Send one item; push stays high after acceptance unless a gap follows.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    sent_reqs.insert(sent_reqs.size(), r);
    in_push <= 1'b1;
    in_dest_base <= r.dest_base;
    in_read_offset <= r.read_offset;
    in_read_length <= r.read_length;
    in_data_length <= r.data_length;
    do @(posedge clk); while (in_full);
  endtask

  // Let every planned segment drain, then write all three registers.
  task automatic set_config(logic [31:0] cs, logic [7:0] k, logic [7:0] si);
    in_push <= 1'b0;
    @(posedge clk);
    while (planned_segs.size() != 0 || sent_reqs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ecsp_pkg::REG_CHUNK_BYTES;
    cfg_data <= cs;
    @(posedge clk);
    cfg_index <= ecsp_pkg::REG_DATA_SHARDS;
    cfg_data <= {24'd0, k};
    @(posedge clk);
    cfg_index <= ecsp_pkg::REG_SHARD_INDEX;
    cfg_data <= {24'd0, si};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_chunk_bytes = cs;
    shard_count = k;
    shard_sel = si;
  endtask

  // Mostly well-formed reads that span a handful of owned chunks; some full-width noise.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    logic [63:0] span;
    span = {32'd0, cur_chunk_bytes} * ({56'd0, shard_count} + 64'd1) * $urandom_range(1, 8);
    r.typed = 1'b0;
    r.seg = '0;
    r.dest_base = rand64();
    pick = $urandom_range(99);
    if (pick < 70) begin
      r.read_offset = (pick < 35) ? {32'd0, $urandom} : rand64();
      r.read_length = (span == 0) ? {48'd0, 16'($urandom)} : (rand64() % span) + 64'd1;
      r.data_length = ($urandom_range(3) == 0) ? (rand64() % (r.read_length + 64'd1))
                                               : 64'hFFFF_FFFF_FFFF_FFFF;
    end else if (pick < 85) begin
      r.read_offset = rand64();
      r.read_length = rand64();
      r.data_length = rand64();
    end else begin
      r.read_offset = rand64();
      r.read_length = ($urandom_range(1) == 0) ? 64'd0 : rand64();
      r.data_length = ($urandom_range(1) == 0) ? 64'd0 : rand64();
    end
    return r;
  endfunction

  request_t directed_rows[] = '{
    '{64'h10, 64'd0, 64'd0, 64'd50, 1'b1, '{64'd0, 64'd0, 64'd0, 1'b1, 1'b0}},
    '{64'h10, 64'd0, 64'd50, 64'd0, 1'b1, '{64'd0, 64'd0, 64'd0, 1'b1, 1'b0}},
    '{64'h1000, 64'd0, 64'd100, 64'd1000, 1'b1, '{64'd0, 64'h1000, 64'd100, 1'b1, 1'b0}},
    '{64'h1000, 64'd0, 64'd100, 64'd40, 1'b1, '{64'd0, 64'h1000, 64'd40, 1'b1, 1'b0}},
    '{64'd0, 64'd100, 64'd10000, 64'd100000, 1'b0, '0},
    '{64'd5, 64'd4000, 64'd8000, 64'd5000, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b0, '0},
    '{64'd0, 64'd0, 64'd1000000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0}
  };

  initial begin
    request_t r;
    logic [31:0] cs;
    logic [7:0]  k;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_dest_base = '0;
    in_read_offset = '0;
    in_read_length = '0;
    in_data_length = '0;
    cfg_we = 1'b0;
    cfg_index = ecsp_pkg::REG_CHUNK_BYTES;
    cfg_data = '0;
    fail_count = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    cur_chunk_bytes = ecsp_pkg::CHUNK_BYTES_RST;
    shard_count = ecsp_pkg::DATA_SHARDS_RST;
    shard_sel = ecsp_pkg::SHARD_INDEX_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset configuration.
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Zero chunk size and zero shard count give empty plans.
    set_config(32'd0, 8'd3, 8'd1);
    send_request('{64'd7, 64'd0, 64'd100, 64'd100, 1'b1, '{64'd0, 64'd0, 64'd0, 1'b1, 1'b0}});
    set_config(32'd512, 8'd0, 8'd0);
    send_request('{64'd7, 64'd0, 64'd100, 64'd100, 1'b1, '{64'd0, 64'd0, 64'd0, 1'b1, 1'b0}});
    // Shard index at or above k, widest k, one-byte chunks that overflow the segment cap.
    set_config(32'd100, 8'd4, 8'd255);
    send_request('{64'd0, 64'd30, 64'd2000, 64'd1500, 1'b0, '0});
    set_config(32'd1, 8'd255, 8'd254);
    send_request('{64'd9, 64'd3, 64'd100000, 64'hFFFF_FFFF, 1'b0, '0});
    set_config(32'd1, 8'd1, 8'd0);
    send_request('{64'd9, 64'd3, 64'd1000, 64'd1000, 1'b0, '0});
    send_request('{64'd9, 64'd3, 64'd64, 64'd1000, 1'b0, '0});
    set_config(32'hFFFF_FFFF, 8'd2, 8'd1);
    send_request('{64'd1, 64'h1_0000_0000, 64'h3_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                   1'b0, '0});

    // Random phases, each with its own configuration and idling pattern.
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(4))
        0: cs = $urandom_range(1, 16);
        1: cs = $urandom_range(1, 4096);
        2: cs = $urandom;
        3: cs = 32'hFFFF_FFFF;
        default: cs = $urandom_range(0, 1) ? 32'd1 : 32'd0;
      endcase
      case ($urandom_range(3))
        0: k = 8'd1;
        1: k = 8'($urandom_range(1, 8));
        2: k = 8'd255;
        default: k = 8'($urandom);
      endcase
      set_config(cs, k, 8'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 71; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 71; end
        default: begin send_idle_pct = 20; pop_stall_pct = 20; end
      endcase
      repeat (38) begin
        r = random_request();
        send_request(r);
      end
    end

    // Drain, then allow the back part time to show any stray result.
    in_push <= 1'b0;
    pop_stall_pct = 0;
    while (planned_segs.size() != 0 || sent_reqs.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && planned_segs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
